// ===== sv/ptacc_pkg.sv =====
package ptacc_pkg;

    // Operation codes carried in the operation field
    localparam logic [2:0] OP_SET  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_EMIT = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] term_coeff;
        logic [15:0]        term_power;
        logic               last_term;
    } term_beat_t;

    typedef struct packed {
        logic signed [31:0] out_coeff;
        logic [15:0]        out_power;
        logic               out_last;
        logic               overflow;
    } result_beat_t;

    // One stored polynomial term
    typedef struct packed {
        logic [31:0] coeff;
        logic [15:0] power;
    } term_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ADD_INIT,
        CMD_MUL_INIT,
        CMD_MUL_TERM_RD,
        CMD_MUL_TERM_LATCH,
        CMD_MRG_RD,
        CMD_MRG_WT,
        CMD_MRG_STEP,
        CMD_COPY_INIT,
        CMD_COPY_RD,
        CMD_COPY_WR,
        CMD_EMIT_INIT,
        CMD_EMIT_RD,
        CMD_EMIT_WT,
        CMD_EMIT_NEXT
    } dp_cmd_t;

    typedef enum logic [1:0] {
        CK_SET,
        CK_MIX2ACC,
        CK_MIX2SCR,
        CK_SCR2ACC
    } copy_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_M_RD,
        S_M_WT,
        S_M_STEP,
        S_MT_CHK,
        S_MT_LAT,
        S_CP_RD,
        S_CP_WR,
        S_FIN,
        S_E_RD,
        S_E_WT,
        S_E_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_cmd_t    cmd;
        copy_kind_t kind;
        logic       negate;
        logic       opd_clear;
    } dp_ctl_t;

    typedef struct packed {
        logic merge_more;
        logic copy_more;
        logic mul_more;
        logic emit_last;
    } dp_stat_t;

endpackage

// ===== sv/ptacc_dpath.sv =====
module ptacc_dpath
    import ptacc_pkg::*;
#(
    parameter int MAX_TERMS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  term_beat_t   term,
    input  dp_ctl_t      ctl,
    output dp_stat_t     stat,
    output result_beat_t result
);

    localparam int IW = $clog2(MAX_TERMS);
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);

    // Term stores
    term_t acc_mem [MAX_TERMS];
    term_t opd_mem [MAX_TERMS];
    term_t scr_mem [MAX_TERMS];
    term_t mix_mem [MAX_TERMS];
    term_t acc_q, opd_q, scr_q, mix_q;
    logic [IW-1:0] acc_raddr, opd_raddr, scr_raddr, mix_raddr;

    // Control registers
    logic [CW-1:0] acc_cnt_reg, acc_cnt_next;
    logic [CW-1:0] opd_cnt_reg, opd_cnt_next;
    logic [CW-1:0] scr_cnt_reg, scr_cnt_next;
    logic [CW-1:0] len_a_reg, len_a_next;
    logic [CW-1:0] len_b_reg, len_b_next;
    logic [CW-1:0] idx_a_reg, idx_a_next;
    logic [CW-1:0] idx_b_reg, idx_b_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] kc_reg, kc_next;
    logic [CW-1:0] k_op_reg, k_op_next;
    logic [CW-1:0] copy_len_reg, copy_len_next;
    logic          ovf_reg, ovf_next;
    logic          a_scr_reg, a_scr_next;
    logic          b_prod_reg, b_prod_next;
    logic          b_neg_reg, b_neg_next;

    // Payload registers
    term_t        a_reg, b_reg, opk_reg;
    logic         b_sat_reg;
    result_beat_t result_reg;

    // Write ports
    logic  opd_we, mix_we, acc_we, scr_we;
    term_t mix_wdata, copy_data;

    // Merge step decision
    logic        a_ok, b_ok, push_en, adv_a, adv_b;
    term_t       push_term;
    logic [31:0] sum_c;

    // Product path
    logic [31:0] prod;
    logic [16:0] psum;

    assign a_ok  = idx_a_reg < len_a_reg;
    assign b_ok  = idx_b_reg < len_b_reg;
    assign sum_c = a_reg.coeff + b_reg.coeff;
    assign prod  = acc_q.coeff * opk_reg.coeff;
    assign psum  = {1'b0, acc_q.power} + {1'b0, opk_reg.power};

    // Pick the head to retire in one merge step
    always_comb
    begin
        push_en   = 1'b0;
        push_term = a_reg;
        adv_a     = 1'b0;
        adv_b     = 1'b0;
        if (a_ok && b_ok)
        begin
            if (a_reg.power > b_reg.power)
            begin
                push_en = 1'b1;
                adv_a   = 1'b1;
            end
            else if (a_reg.power < b_reg.power)
            begin
                push_en   = 1'b1;
                push_term = b_reg;
                adv_b     = 1'b1;
            end
            else
            begin
                push_en   = (sum_c != 32'd0);
                push_term = '{coeff: sum_c, power: a_reg.power};
                adv_a     = 1'b1;
                adv_b     = 1'b1;
            end
        end
        else if (a_ok)
        begin
            push_en = !(a_reg.coeff == 32'd0 && a_reg.power == 16'd0);
            adv_a   = 1'b1;
        end
        else if (b_ok)
        begin
            push_en   = !(b_reg.coeff == 32'd0 && b_reg.power == 16'd0);
            push_term = b_reg;
            adv_b     = 1'b1;
        end
    end

    // Select copy source
    always_comb
    begin
        case (ctl.kind)
            CK_SET:     copy_data = opd_q;
            CK_MIX2ACC: copy_data = mix_q;
            CK_MIX2SCR: copy_data = mix_q;
            CK_SCR2ACC: copy_data = scr_q;
            default:    copy_data = mix_q;
        endcase
    end

    // Read addresses
    always_comb
    begin
        acc_raddr = b_prod_reg ? idx_b_reg[IW-1:0] : idx_a_reg[IW-1:0];
        if (ctl.cmd == CMD_EMIT_RD)
        begin
            acc_raddr = kc_reg[IW-1:0];
        end
        opd_raddr = idx_b_reg[IW-1:0];
        if (ctl.cmd == CMD_MUL_TERM_RD)
        begin
            opd_raddr = k_op_reg[IW-1:0];
        end
        else if (ctl.cmd == CMD_COPY_RD)
        begin
            opd_raddr = kc_reg[IW-1:0];
        end
        scr_raddr = (ctl.cmd == CMD_COPY_RD) ? kc_reg[IW-1:0] : idx_a_reg[IW-1:0];
        mix_raddr = kc_reg[IW-1:0];
    end

    // Next values of control registers and write enables
    always_comb
    begin
        acc_cnt_next  = acc_cnt_reg;
        opd_cnt_next  = opd_cnt_reg;
        scr_cnt_next  = scr_cnt_reg;
        len_a_next    = len_a_reg;
        len_b_next    = len_b_reg;
        idx_a_next    = idx_a_reg;
        idx_b_next    = idx_b_reg;
        n_next        = n_reg;
        kc_next       = kc_reg;
        k_op_next     = k_op_reg;
        copy_len_next = copy_len_reg;
        ovf_next      = ovf_reg;
        a_scr_next    = a_scr_reg;
        b_prod_next   = b_prod_reg;
        b_neg_next    = b_neg_reg;
        opd_we        = 1'b0;
        mix_we        = 1'b0;
        acc_we        = 1'b0;
        scr_we        = 1'b0;
        mix_wdata     = push_term;
        case (ctl.cmd)
            CMD_LOAD:
            begin
                if (term.term_coeff != 32'sd0)
                begin
                    if (opd_cnt_reg < MAX_CNT)
                    begin
                        opd_we       = 1'b1;
                        opd_cnt_next = opd_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            CMD_ADD_INIT:
            begin
                idx_a_next  = '0;
                idx_b_next  = '0;
                n_next      = '0;
                len_a_next  = acc_cnt_reg;
                len_b_next  = opd_cnt_reg;
                a_scr_next  = 1'b0;
                b_prod_next = 1'b0;
                b_neg_next  = ctl.negate;
            end
            CMD_MUL_INIT:
            begin
                scr_cnt_next = '0;
                k_op_next    = '0;
            end
            CMD_MUL_TERM_LATCH:
            begin
                idx_a_next  = '0;
                idx_b_next  = '0;
                n_next      = '0;
                len_a_next  = scr_cnt_reg;
                len_b_next  = acc_cnt_reg;
                a_scr_next  = 1'b1;
                b_prod_next = 1'b1;
                b_neg_next  = 1'b0;
            end
            CMD_MRG_STEP:
            begin
                if (push_en)
                begin
                    if (n_reg < MAX_CNT)
                    begin
                        mix_we = 1'b1;
                        n_next = n_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (adv_a)
                begin
                    idx_a_next = idx_a_reg + CW'(1);
                end
                if (adv_b)
                begin
                    idx_b_next = idx_b_reg + CW'(1);
                    if (b_sat_reg)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            CMD_COPY_INIT:
            begin
                kc_next = '0;
                case (ctl.kind)
                    CK_SET:
                    begin
                        copy_len_next = opd_cnt_reg;
                        acc_cnt_next  = opd_cnt_reg;
                    end
                    CK_MIX2ACC:
                    begin
                        copy_len_next = n_reg;
                        acc_cnt_next  = n_reg;
                    end
                    CK_MIX2SCR:
                    begin
                        copy_len_next = n_reg;
                        scr_cnt_next  = n_reg;
                        k_op_next     = k_op_reg + CW'(1);
                    end
                    CK_SCR2ACC:
                    begin
                        copy_len_next = scr_cnt_reg;
                        acc_cnt_next  = scr_cnt_reg;
                    end
                    default:
                    begin
                        copy_len_next = '0;
                    end
                endcase
            end
            CMD_COPY_WR:
            begin
                if (ctl.kind == CK_MIX2SCR)
                begin
                    scr_we = 1'b1;
                end
                else
                begin
                    acc_we = 1'b1;
                end
                kc_next = kc_reg + CW'(1);
            end
            CMD_EMIT_INIT:
            begin
                kc_next = '0;
            end
            CMD_EMIT_NEXT:
            begin
                kc_next = kc_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
        if (ctl.opd_clear)
        begin
            opd_cnt_next = '0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg  <= '0;
            opd_cnt_reg  <= '0;
            scr_cnt_reg  <= '0;
            len_a_reg    <= '0;
            len_b_reg    <= '0;
            idx_a_reg    <= '0;
            idx_b_reg    <= '0;
            n_reg        <= '0;
            kc_reg       <= '0;
            k_op_reg     <= '0;
            copy_len_reg <= '0;
            ovf_reg      <= 1'b0;
            a_scr_reg    <= 1'b0;
            b_prod_reg   <= 1'b0;
            b_neg_reg    <= 1'b0;
        end
        else
        begin
            acc_cnt_reg  <= acc_cnt_next;
            opd_cnt_reg  <= opd_cnt_next;
            scr_cnt_reg  <= scr_cnt_next;
            len_a_reg    <= len_a_next;
            len_b_reg    <= len_b_next;
            idx_a_reg    <= idx_a_next;
            idx_b_reg    <= idx_b_next;
            n_reg        <= n_next;
            kc_reg       <= kc_next;
            k_op_reg     <= k_op_next;
            copy_len_reg <= copy_len_next;
            ovf_reg      <= ovf_next;
            a_scr_reg    <= a_scr_next;
            b_prod_reg   <= b_prod_next;
            b_neg_reg    <= b_neg_next;
        end
    end

    // Memories with registered reads
    always_ff @(posedge clk)
    begin
        if (opd_we)
        begin
            opd_mem[opd_cnt_reg[IW-1:0]] <= '{coeff: term.term_coeff, power: term.term_power};
        end
        if (mix_we)
        begin
            mix_mem[n_reg[IW-1:0]] <= mix_wdata;
        end
        if (acc_we)
        begin
            acc_mem[kc_reg[IW-1:0]] <= copy_data;
        end
        if (scr_we)
        begin
            scr_mem[kc_reg[IW-1:0]] <= copy_data;
        end
        acc_q <= acc_mem[acc_raddr];
        opd_q <= opd_mem[opd_raddr];
        scr_q <= scr_mem[scr_raddr];
        mix_q <= mix_mem[mix_raddr];
    end

    // Load merge heads, operand term and output beat
    always_ff @(posedge clk)
    begin
        if (ctl.cmd == CMD_MUL_TERM_LATCH)
        begin
            opk_reg <= opd_q;
        end
        if (ctl.cmd == CMD_MRG_WT)
        begin
            a_reg <= a_scr_reg ? scr_q : acc_q;
            if (b_prod_reg)
            begin
                b_reg.coeff <= prod;
                b_reg.power <= psum[16] ? 16'hFFFF : psum[15:0];
                b_sat_reg   <= psum[16];
            end
            else
            begin
                b_reg.coeff <= b_neg_reg ? 32'(32'd0 - opd_q.coeff) : opd_q.coeff;
                b_reg.power <= opd_q.power;
                b_sat_reg   <= 1'b0;
            end
        end
        if (ctl.cmd == CMD_EMIT_WT)
        begin
            if (acc_cnt_reg == '0)
            begin
                result_reg.out_coeff <= '0;
                result_reg.out_power <= '0;
            end
            else
            begin
                result_reg.out_coeff <= acc_q.coeff;
                result_reg.out_power <= acc_q.power;
            end
            result_reg.out_last <= stat.emit_last;
            result_reg.overflow <= ovf_reg;
        end
    end

    assign stat.merge_more = a_ok || b_ok;
    assign stat.copy_more  = kc_reg < copy_len_reg;
    assign stat.mul_more   = k_op_reg < opd_cnt_reg;
    assign stat.emit_last  = (acc_cnt_reg == '0) || ((kc_reg + CW'(1)) == acc_cnt_reg);
    assign result          = result_reg;

endmodule

// ===== sv/ptacc_ctrl.sv =====
module ptacc_ctrl
    import ptacc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       term_valid,
    input  logic [2:0] term_op,
    input  logic       term_last,
    output logic       term_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  dp_stat_t   stat,
    output dp_ctl_t    ctl
);

    ctrl_state_t state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    copy_kind_t  kind_reg, kind_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SET;
            kind_reg  <= CK_SET;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            kind_reg  <= kind_next;
        end
    end

    // Sequence the datapath
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        kind_next     = kind_reg;
        ctl.cmd       = CMD_NONE;
        ctl.kind      = kind_reg;
        ctl.negate    = (op_reg == OP_SUB);
        ctl.opd_clear = 1'b0;
        term_stall    = (state_reg != S_IDLE);
        result_valid  = (state_reg == S_E_OUT);
        case (state_reg)
            S_IDLE:
            begin
                if (term_valid)
                begin
                    if (term_op == OP_EMIT)
                    begin
                        ctl.cmd    = CMD_EMIT_INIT;
                        state_next = S_E_RD;
                    end
                    else if (term_op == OP_SET || term_op == OP_ADD ||
                             term_op == OP_SUB || term_op == OP_MUL)
                    begin
                        ctl.cmd = CMD_LOAD;
                        if (term_last)
                        begin
                            op_next    = term_op;
                            state_next = S_DISPATCH;
                        end
                    end
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_SET:
                    begin
                        ctl.cmd    = CMD_COPY_INIT;
                        ctl.kind   = CK_SET;
                        kind_next  = CK_SET;
                        state_next = S_CP_RD;
                    end
                    OP_ADD, OP_SUB:
                    begin
                        ctl.cmd    = CMD_ADD_INIT;
                        state_next = S_M_RD;
                    end
                    OP_MUL:
                    begin
                        ctl.cmd    = CMD_MUL_INIT;
                        state_next = S_MT_CHK;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_M_RD:
            begin
                if (stat.merge_more)
                begin
                    ctl.cmd    = CMD_MRG_RD;
                    state_next = S_M_WT;
                end
                else
                begin
                    ctl.cmd    = CMD_COPY_INIT;
                    ctl.kind   = (op_reg == OP_MUL) ? CK_MIX2SCR : CK_MIX2ACC;
                    kind_next  = ctl.kind;
                    state_next = S_CP_RD;
                end
            end
            S_M_WT:
            begin
                ctl.cmd    = CMD_MRG_WT;
                state_next = S_M_STEP;
            end
            S_M_STEP:
            begin
                ctl.cmd    = CMD_MRG_STEP;
                state_next = S_M_RD;
            end
            S_MT_CHK:
            begin
                if (stat.mul_more)
                begin
                    ctl.cmd    = CMD_MUL_TERM_RD;
                    state_next = S_MT_LAT;
                end
                else
                begin
                    ctl.cmd    = CMD_COPY_INIT;
                    ctl.kind   = CK_SCR2ACC;
                    kind_next  = CK_SCR2ACC;
                    state_next = S_CP_RD;
                end
            end
            S_MT_LAT:
            begin
                ctl.cmd    = CMD_MUL_TERM_LATCH;
                state_next = S_M_RD;
            end
            S_CP_RD:
            begin
                if (stat.copy_more)
                begin
                    ctl.cmd    = CMD_COPY_RD;
                    state_next = S_CP_WR;
                end
                else if (kind_reg == CK_MIX2SCR)
                begin
                    state_next = S_MT_CHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CP_WR:
            begin
                ctl.cmd    = CMD_COPY_WR;
                state_next = S_CP_RD;
            end
            S_FIN:
            begin
                // drop the consumed operand
                ctl.opd_clear = 1'b1;
                state_next    = S_IDLE;
            end
            S_E_RD:
            begin
                ctl.cmd    = CMD_EMIT_RD;
                state_next = S_E_WT;
            end
            S_E_WT:
            begin
                ctl.cmd    = CMD_EMIT_WT;
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                if (!result_stall)
                begin
                    ctl.cmd    = CMD_EMIT_NEXT;
                    state_next = stat.emit_last ? S_IDLE : S_E_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/polynomial_term_accumulator_unit.sv =====
// Operand beats that are not last are taken while idle. Set, add and subtract
// run once the last operand beat is in; multiply repeats the merge of add and
// subtract and a copy once per operand term.
// Emit presents one result beat at a time and holds it while result_stall is high.
// Reset clears counts, overflow flag and sequencer; term memories need no clearing.
module polynomial_term_accumulator_unit
    import ptacc_pkg::*;
#(
    parameter int MAX_TERMS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  term_beat_t   term,
    input  logic         term_valid,
    output logic         term_stall,
    output result_beat_t result,
    output logic         result_valid,
    input  logic         result_stall
);

    dp_ctl_t  ctl;
    dp_stat_t stat;

    ptacc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .term_valid   (term_valid),
        .term_op      (term.operation),
        .term_last    (term.last_term),
        .term_stall   (term_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .ctl          (ctl)
    );

    ptacc_dpath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .term   (term),
        .ctl    (ctl),
        .stat   (stat),
        .result (result)
    );

endmodule
